@@ rtl/ssts_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted set table package
// Shared widths, operation and status codes and the cell control bundle.
// ----------------------------------------------------------------------------
package ssts_pkg;

  localparam int DEFAULT_CAPACITY = 16;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // in_tdata: action, item_value, position -> 42 bits, padded to 48
  localparam int IN_DATA_W  = 48;
  // out_tdata: status, entry_value, entry_count -> 39 bits, padded to 40
  localparam int OUT_DATA_W = 40;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_OOR  = 2'd3
  } status_t;

  // Per-cycle commands broadcast to every cell of the row
  typedef struct packed {
    logic cmp_en;  // register compare flags and the read tap
    logic ins_en;  // open a slot and place the key
    logic del_en;  // close the gap at the position
  } cell_ctl_t;

endpackage

@@ rtl/ssts_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted set table cell
// Holds one entry, compares it with the key and trades values with its
// neighbours to open or close a slot in the ordered row.
// ----------------------------------------------------------------------------
module ssts_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                                   clk,
  input  ssts_pkg::cell_ctl_t                    ctl,
  input  logic signed [ssts_pkg::VALUE_W-1:0]    key,
  input  logic        [ssts_pkg::POS_W-1:0]      pos,
  input  logic        [CNT_W-1:0]                count,
  input  logic signed [ssts_pkg::VALUE_W-1:0]    left_value,
  input  logic                                   left_lt,
  input  logic signed [ssts_pkg::VALUE_W-1:0]    right_value,
  output logic signed [ssts_pkg::VALUE_W-1:0]    value,
  output logic                                   lt,
  output logic                                   eq,
  output logic        [ssts_pkg::VALUE_W-1:0]    hit
);

  localparam logic [CNT_W-1:0]           IDX_CNT = CNT_W'(IDX);
  localparam logic [ssts_pkg::POS_W-1:0] IDX_POS = ssts_pkg::POS_W'(IDX);

  logic signed [ssts_pkg::VALUE_W-1:0] value_r;
  logic                                lt_r;
  logic                                eq_r;
  logic        [ssts_pkg::VALUE_W-1:0] hit_r;
  logic                                occupied;
  logic                                at_or_after;

  assign occupied    = IDX_CNT < count;
  assign at_or_after = IDX_POS >= pos;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      // an empty cell counts as greater than any key
      lt_r  <= !occupied || (key < value_r);
      eq_r  <= occupied && (key == value_r);
      hit_r <= (IDX_POS == pos) ? value_r : '0;
    end
    if (ctl.ins_en && lt_r) begin
      // shift up if the left neighbour also moves, else take the key
      value_r <= left_lt ? left_value : key;
    end else if (ctl.del_en && at_or_after) begin
      value_r <= right_value;
    end
  end

  assign value = value_r;
  assign lt    = lt_r;
  assign eq    = eq_r;
  assign hit   = hit_r;

endmodule

@@ rtl/sorted_set_table_unit.sv @@
// Each item passes through accept, compare across the cell row, then shift
// the row and load the result register; a new item is taken only once the
// last one is through. A stalled result register holds the item in its last
// step. Reset (rst_n low, synchronous) empties the table and drops any
// pending result; stored values are not cleared and are never read before
// being written.
// ----------------------------------------------------------------------------
// Sorted set table unit
// Ordered set of distinct signed values held in a row of compare-and-shift
// cells; supports insert, delete at a position and read at a position.
// ----------------------------------------------------------------------------
module sorted_set_table_unit #(
  parameter int CAPACITY = ssts_pkg::DEFAULT_CAPACITY
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [1:0] action, [33:2] item_value, [41:34] position, [47:42] zero
  input  logic [ssts_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [33:2] entry_value, [38:34] entry_count, [39] zero
  output logic [ssts_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = CNT_W + ssts_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] count_r, count_nxt;

  ssts_pkg::action_t                   action_r;
  logic signed [ssts_pkg::VALUE_W-1:0] key_r;
  logic        [ssts_pkg::POS_W-1:0]   pos_r;

  logic                                out_valid_r, out_valid_nxt;
  ssts_pkg::status_t                   out_status_r, status_nxt;
  logic        [ssts_pkg::VALUE_W-1:0] out_value_r, value_nxt;
  logic        [ssts_pkg::COUNT_W-1:0] out_count_r;

  ssts_pkg::cell_ctl_t ctl;

  logic signed [ssts_pkg::VALUE_W-1:0] cell_value [CAPACITY];
  logic        [CAPACITY-1:0]          cell_lt;
  logic        [CAPACITY-1:0]          cell_eq;
  logic        [ssts_pkg::VALUE_W-1:0] cell_hit   [CAPACITY];

  logic                                in_fire;
  logic                                exec_go;
  logic                                dup;
  logic                                full;
  logic                                out_of_range;
  logic        [ssts_pkg::VALUE_W-1:0] rd_word;
  logic        [CNT_W+ssts_pkg::COUNT_W-1:0] count_ext;

  assign in_tready = state_r == S_IDLE;
  assign in_fire   = in_tvalid && in_tready;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // ---- cell row --------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ssts_pkg::VALUE_W-1:0] left_v;
    logic                                left_l;
    logic signed [ssts_pkg::VALUE_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = key_r;
      assign left_l = 1'b0;
    end else begin : g_mid
      assign left_v = cell_value[i-1];
      assign left_l = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_value[i];
    end else begin : g_inner
      assign right_v = cell_value[i+1];
    end

    ssts_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .key         (key_r),
      .pos         (pos_r),
      .count       (count_r),
      .left_value  (left_v),
      .left_lt     (left_l),
      .right_value (right_v),
      .value       (cell_value[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i]),
      .hit         (cell_hit[i])
    );
  end

  // Only the cell at the position drives a non-zero tap
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_hit[i];
    end
  end

  assign dup          = |cell_eq;
  assign full         = count_r == CNT_W'(CAPACITY);
  assign out_of_range = CMP_W'(pos_r) >= CMP_W'(count_r);

  // ---- decision --------------------------------------------------------------
  always_comb begin
    ctl            = '0;
    ctl.cmp_en     = state_r == S_CMP;
    count_nxt      = count_r;
    status_nxt     = ssts_pkg::ST_OK;
    value_nxt      = '0;
    unique case (action_r)
      ssts_pkg::ACT_INSERT: begin
        if (dup) begin
          status_nxt = ssts_pkg::ST_DUP;
        end else if (full) begin
          status_nxt = ssts_pkg::ST_FULL;
        end else begin
          ctl.ins_en = exec_go;
          count_nxt  = count_r + 1'b1;
        end
      end
      ssts_pkg::ACT_DELETE: begin
        if (out_of_range) begin
          status_nxt = ssts_pkg::ST_OOR;
        end else begin
          ctl.del_en = exec_go;
          value_nxt  = rd_word;
          count_nxt  = count_r - 1'b1;
        end
      end
      ssts_pkg::ACT_READ: begin
        if (out_of_range) begin
          status_nxt = ssts_pkg::ST_OOR;
        end else begin
          value_nxt = rd_word;
        end
      end
      ssts_pkg::ACT_NONE: begin
        status_nxt = ssts_pkg::ST_OK;
      end
      default: begin
        status_nxt = ssts_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: if (exec_go) begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign count_ext = (CNT_W + ssts_pkg::COUNT_W)'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_r <= ssts_pkg::action_t'(in_tdata[1:0]);
      key_r    <= $signed(in_tdata[33:2]);
      pos_r    <= in_tdata[41:34];
    end
    if (exec_go) begin
      out_status_r <= status_nxt;
      out_value_r  <= value_nxt;
      out_count_r  <= count_ext[ssts_pkg::COUNT_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_value_r, out_status_r};

endmodule

@@ rtl/ssts_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted set table checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ssts_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ssts_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [ssts_pkg::STATUS_W-1:0] st;
  logic [ssts_pkg::VALUE_W-1:0]  ev;

  assign st = out_tdata[1:0];
  assign ev = out_tdata[33:2];

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // drop any pending result on reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // one item in flight: no new transaction straight after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while item in flight");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == ssts_pkg::ST_OOR || st == ssts_pkg::ST_DUP ||
                   st == ssts_pkg::ST_FULL) |-> ev == '0)
    else $error("error result carries a value");

endmodule

bind sorted_set_table_unit ssts_checker u_ssts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
